FILE: src/itb_pkg.sv
package itb_pkg;

  localparam int BUCKET_W   = 8;
  localparam int CTIME_W    = 48;
  localparam int TOKEN_W    = 32;
  localparam int PERIOD_W   = 41;
  localparam int SESS_W     = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 41;
  localparam int ACC_W      = 34;
  localparam int S_TDATA_W  = 96;
  localparam int M_TDATA_W  = 80;

  localparam logic [TOKEN_W-1:0]  MAX_TOKENS_RST    = 32'd16;
  localparam logic [TOKEN_W-1:0]  REFILL_TOKENS_RST = 32'd16;
  localparam logic [PERIOD_W-1:0] REFILL_PERIOD_RST = 41'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_TOKENS    = 2'd0,
    CFG_REFILL_TOKENS = 2'd1,
    CFG_REFILL_PERIOD = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_CALC,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic                done;
    logic                ovf;
    logic [ACC_W-1:0]    prod;
    logic [PERIOD_W-1:0] rem;
  } ser_res_t;

endpackage

FILE: src/itb_serial.sv
module itb_serial #(
  parameter int TIME_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [TIME_BITS-1:0]          dividend_i,
  input  logic [itb_pkg::PERIOD_W-1:0]  divisor_i,
  input  logic [itb_pkg::TOKEN_W-1:0]   mult_i,
  output itb_pkg::ser_res_t             res_o
);

  localparam int CNT_W = $clog2(TIME_BITS);

  logic                         busy_q, busy_d;
  logic                         done_q, done_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [TIME_BITS-1:0]         dvd_q, dvd_d;
  logic [itb_pkg::PERIOD_W-1:0] div_q, div_d;
  logic [itb_pkg::TOKEN_W-1:0]  mul_q, mul_d;
  logic [itb_pkg::PERIOD_W-1:0] rem_q, rem_d;
  logic [itb_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic                         ovf_q, ovf_d;

  always_comb begin
    logic [itb_pkg::PERIOD_W:0] r2;
    logic [itb_pkg::PERIOD_W:0] diff;
    logic                       ge;
    logic [itb_pkg::ACC_W:0]    acc_nx;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    mul_d  = mul_q;
    rem_d  = rem_q;
    acc_d  = acc_q;
    ovf_d  = ovf_q;
    r2     = {rem_q, dvd_q[TIME_BITS-1]};
    diff   = r2 - {1'b0, div_q};
    ge     = (r2 >= {1'b0, div_q});
    // quotient bits come out msb first: Horner accumulate of quotient * mult
    acc_nx = {acc_q, 1'b0} + (ge ? (itb_pkg::ACC_W+1)'(mul_q) : '0);
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(TIME_BITS - 1);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      mul_d  = mult_i;
      rem_d  = '0;
      acc_d  = '0;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      rem_d = ge ? diff[itb_pkg::PERIOD_W-1:0] : r2[itb_pkg::PERIOD_W-1:0];
      dvd_d = {dvd_q[TIME_BITS-2:0], 1'b0};
      acc_d = acc_nx[itb_pkg::ACC_W-1:0];
      // sticky once the product reaches 2^33, beyond any token count
      ovf_d = ovf_q | acc_nx[itb_pkg::ACC_W] | acc_nx[itb_pkg::ACC_W-1];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
    mul_q <= mul_d;
    rem_q <= rem_d;
    acc_q <= acc_d;
    ovf_q <= ovf_d;
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.prod = acc_q;
  assign res_o.rem  = rem_q;

endmodule

FILE: src/itb_store.sv
module itb_store #(
  parameter int DEPTH     = 256,
  parameter int AW        = 8,
  parameter int TIME_BITS = 48
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [AW-1:0]                rd_addr_i,
  output logic [itb_pkg::TOKEN_W-1:0]  rd_tokens_o,
  output logic [TIME_BITS-1:0]         rd_last_o,
  output logic                         rd_valid_o,
  output logic [itb_pkg::SESS_W-1:0]   rd_sess_o,
  input  logic [AW-1:0]                wr_addr_i,
  input  logic                         wr_a_en_i,
  input  logic [itb_pkg::TOKEN_W-1:0]  wr_tokens_i,
  input  logic [TIME_BITS-1:0]         wr_last_i,
  input  logic                         wr_b_en_i,
  input  logic                         wr_valid_i,
  input  logic [itb_pkg::SESS_W-1:0]   wr_sess_i
);

  localparam int A_W = itb_pkg::TOKEN_W + TIME_BITS;
  localparam int B_W = 1 + itb_pkg::SESS_W;

  // bucket counts and refill marks: no reset, read only once valid
  logic [A_W-1:0] mem_a [DEPTH];
  // valid flag and session start: cleared by the sweep after reset
  logic [B_W-1:0] mem_b [DEPTH];
  logic [A_W-1:0] rd_a_q;
  logic [B_W-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_a_en_i) begin
      mem_a[wr_addr_i] <= {wr_tokens_i, wr_last_i};
    end
    if (rd_en_i) begin
      rd_a_q <= mem_a[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b_en_i) begin
      mem_b[wr_addr_i] <= {wr_valid_i, wr_sess_i};
    end
    if (rd_en_i) begin
      rd_b_q <= mem_b[rd_addr_i];
    end
  end

  assign rd_tokens_o = rd_a_q[A_W-1:TIME_BITS];
  assign rd_last_o   = rd_a_q[TIME_BITS-1:0];
  assign rd_valid_o  = rd_b_q[B_W-1];
  assign rd_sess_o   = rd_b_q[itb_pkg::SESS_W-1:0];

endmodule

FILE: src/interval_token_bucket_table.sv
// Per request: IDLE accepts it, READ fetches the bucket, LOAD starts the divider, DIV
// waits for it, CALC refills and WRITE outputs, storing the bucket if take is nonzero;
// a never-written bucket skips DIV. No request is taken until WRITE ends, which waits
// for the output; the radix-2 serial divider also accumulates periods * refill_tokens.
// Reset: asynchronous, active low; afterwards a sweep over all NUM_BUCKETS entries clears
// the valid flags and session times, with s_axis_tready_o low until it ends.
module interval_token_bucket_table #(
  parameter int NUM_BUCKETS = 256,
  parameter int TIME_BITS   = 48
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [7:0] bucket, [55:8] client_time, [87:56] take, [88] strict, [89] track_session
  input  logic [itb_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] available, [79:32] session_start
  output logic [itb_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  input  logic                            cfg_we_i,
  input  logic [itb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [itb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int IDX_W = $clog2(NUM_BUCKETS);
  localparam int WR_W  = 25;

  itb_pkg::state_e st_q, st_d;
  logic [IDX_W-1:0] clr_q, clr_d;

  logic [itb_pkg::TOKEN_W-1:0]  max_q, refill_q;
  logic [itb_pkg::PERIOD_W-1:0] period_q;

  logic [IDX_W-1:0]            idx_q;
  logic [TIME_BITS-1:0]        now_q;
  logic [itb_pkg::TOKEN_W-1:0] take_q;
  logic                        strict_q, track_q;
  logic                        span_pos_q;
  logic [itb_pkg::TOKEN_W-1:0] avail_q;
  logic [TIME_BITS-1:0]        mark_q;

  logic                        m_valid_q;
  logic [itb_pkg::TOKEN_W-1:0] m_avail_q;
  logic [itb_pkg::SESS_W-1:0]  m_sess_q;

  logic [IDX_W-1:0] in_idx;
  logic             in_load;

  logic                         rd_en;
  logic [itb_pkg::TOKEN_W-1:0]  rd_tokens;
  logic [TIME_BITS-1:0]         rd_last;
  logic                         rd_valid;
  logic [itb_pkg::SESS_W-1:0]   rd_sess;
  logic [IDX_W-1:0]             wr_addr;
  logic                         wr_a_en, wr_b_en, wr_valid;
  logic [itb_pkg::SESS_W-1:0]   wr_sess;
  logic [itb_pkg::TOKEN_W-1:0]  left;
  logic [TIME_BITS-1:0]         last_new;
  logic                         enough;
  logic [itb_pkg::SESS_W-1:0]   now48;
  logic [itb_pkg::SESS_W-1:0]   sess_next;

  logic                         ser_start;
  logic [TIME_BITS-1:0]         span;
  logic [itb_pkg::PERIOD_W-1:0] period_eff;
  itb_pkg::ser_res_t            ser_res;

  logic [itb_pkg::TOKEN_W-1:0]  calc_avail;
  logic [TIME_BITS-1:0]         calc_mark;
  logic                         out_free;
  logic                         out_load;

  // bucket index modulo NUM_BUCKETS by restoring subtraction
  always_comb begin
    logic [WR_W-1:0] r;
    r = WR_W'(s_axis_tdata_i[itb_pkg::BUCKET_W-1:0]);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (WR_W'(NUM_BUCKETS) << k)) begin
        r = r - (WR_W'(NUM_BUCKETS) << k);
      end
    end
    in_idx = IDX_W'(r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= itb_pkg::MAX_TOKENS_RST;
      refill_q <= itb_pkg::REFILL_TOKENS_RST;
      period_q <= itb_pkg::REFILL_PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        itb_pkg::CFG_MAX_TOKENS:    max_q    <= cfg_data_i[itb_pkg::TOKEN_W-1:0];
        itb_pkg::CFG_REFILL_TOKENS: refill_q <= cfg_data_i[itb_pkg::TOKEN_W-1:0];
        itb_pkg::CFG_REFILL_PERIOD: period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign period_eff = (period_q == '0) ? itb_pkg::PERIOD_W'(1) : period_q;
  assign span       = (now_q > rd_last) ? now_q - rd_last : '0;
  assign out_free   = !m_valid_q || m_axis_tready_i;

  itb_serial #(
    .TIME_BITS(TIME_BITS)
  ) u_serial (
    .clk_i,
    .rst_ni,
    .start_i   (ser_start),
    .dividend_i(span),
    .divisor_i (period_eff),
    .mult_i    (refill_q),
    .res_o     (ser_res)
  );

  itb_store #(
    .DEPTH    (NUM_BUCKETS),
    .AW       (IDX_W),
    .TIME_BITS(TIME_BITS)
  ) u_store (
    .clk_i,
    .rd_en_i    (rd_en),
    .rd_addr_i  (idx_q),
    .rd_tokens_o(rd_tokens),
    .rd_last_o  (rd_last),
    .rd_valid_o (rd_valid),
    .rd_sess_o  (rd_sess),
    .wr_addr_i  (wr_addr),
    .wr_a_en_i  (wr_a_en),
    .wr_tokens_i(left),
    .wr_last_i  (last_new),
    .wr_b_en_i  (wr_b_en),
    .wr_valid_i (wr_valid),
    .wr_sess_i  (wr_sess)
  );

  // refill: min(periods * refill_tokens + tokens, max_tokens); a never-written bucket starts at max_tokens
  always_comb begin
    logic [itb_pkg::ACC_W:0] sum;
    sum = (itb_pkg::ACC_W+1)'(ser_res.prod) + (itb_pkg::ACC_W+1)'(rd_tokens);
    if (!rd_valid) begin
      calc_avail = max_q;
      calc_mark  = now_q;
    end else begin
      if (ser_res.ovf || sum >= (itb_pkg::ACC_W+1)'(max_q)) begin
        calc_avail = max_q;
      end else begin
        calc_avail = sum[itb_pkg::TOKEN_W-1:0];
      end
      calc_mark = span_pos_q ? now_q - TIME_BITS'(ser_res.rem) : rd_last;
    end
  end

  assign enough    = (avail_q >= take_q);
  assign left      = enough ? avail_q - take_q : '0;
  assign last_new  = (strict_q && left == '0) ? now_q : mark_q;
  assign now48     = itb_pkg::SESS_W'(now_q);
  assign sess_next = (track_q && enough && take_q != '0) ? now48 : rd_sess;

  always_comb begin
    st_d      = st_q;
    clr_d     = clr_q;
    s_axis_tready_o = 1'b0;
    in_load   = 1'b0;
    rd_en     = 1'b0;
    ser_start = 1'b0;
    wr_addr   = idx_q;
    wr_a_en   = 1'b0;
    wr_b_en   = 1'b0;
    wr_valid  = 1'b1;
    wr_sess   = sess_next;
    out_load  = 1'b0;
    case (st_q)
      itb_pkg::ST_CLEAR: begin
        wr_addr  = clr_q;
        wr_b_en  = 1'b1;
        wr_valid = 1'b0;
        wr_sess  = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == IDX_W'(NUM_BUCKETS - 1)) begin
          st_d = itb_pkg::ST_IDLE;
        end
      end
      itb_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          in_load = 1'b1;
          st_d    = itb_pkg::ST_READ;
        end
      end
      itb_pkg::ST_READ: begin
        rd_en = 1'b1;
        st_d  = itb_pkg::ST_LOAD;
      end
      itb_pkg::ST_LOAD: begin
        if (rd_valid) begin
          ser_start = 1'b1;
          st_d      = itb_pkg::ST_DIV;
        end else begin
          st_d = itb_pkg::ST_CALC;
        end
      end
      itb_pkg::ST_DIV: begin
        if (ser_res.done) begin
          st_d = itb_pkg::ST_CALC;
        end
      end
      itb_pkg::ST_CALC: begin
        st_d = itb_pkg::ST_WRITE;
      end
      itb_pkg::ST_WRITE: begin
        if (out_free) begin
          out_load = 1'b1;
          if (take_q != '0) begin
            wr_a_en = 1'b1;
            wr_b_en = 1'b1;
          end
          st_d = itb_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = itb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= itb_pkg::ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      clr_q <= clr_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      idx_q    <= in_idx;
      now_q    <= TIME_BITS'(s_axis_tdata_i[55:8]);
      take_q   <= s_axis_tdata_i[87:56];
      strict_q <= s_axis_tdata_i[88];
      track_q  <= s_axis_tdata_i[89];
    end
    if (st_q == itb_pkg::ST_LOAD) begin
      span_pos_q <= (now_q > rd_last);
    end
    if (st_q == itb_pkg::ST_CALC) begin
      avail_q <= calc_avail;
      mark_q  <= calc_mark;
    end
    if (out_load) begin
      m_avail_q <= avail_q;
      m_sess_q  <= track_q ? sess_next : '0;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_sess_q, m_avail_q};

`ifndef NO_ASSERTIONS
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_res.done |-> st_q == itb_pkg::ST_DIV)
    else $error("divider finished outside the divide phase");

  a_out_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(st_q == itb_pkg::ST_WRITE))
    else $error("result appeared without a write phase");

  a_avail_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == itb_pkg::ST_WRITE) |-> avail_q <= max_q)
    else $error("available count above capacity");

  a_no_out_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == itb_pkg::ST_CLEAR) |-> !m_axis_tvalid_o)
    else $error("result during clearing sweep");
`endif

endmodule
